### rtl/postfix_expression_evaluator_unit_assert.svh
// assertion macros for the postfix evaluator
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH

`define PEE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define PEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/pee_pkg.sv
package pee_pkg;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_MUL   = 8'h2a;
    localparam logic [7:0] CH_DIV   = 8'h2f;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNDER   = 2'd1;
    localparam logic [1:0] ST_OVER    = 2'd2;
    localparam logic [1:0] ST_DIVZERO = 2'd3;

    typedef enum logic [2:0] {
        OP_NONE, OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_DIV
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] digit;
        logic       last;
    } cmd_t;
endpackage

### rtl/pee_front.sv
module pee_front
    import pee_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] symbol,
    input  logic       last,
    input  logic       in_valid,
    output logic       in_ready,
    output cmd_t       cmd,
    output logic       cmd_valid,
    input  logic       cmd_ready
);
    cmd_t q_reg [2];
    logic [1:0] cnt_reg;
    logic wp_reg, rp_reg;
    cmd_t c;

    always_comb begin
        c.op = OP_NONE;
        c.digit = symbol[3:0];
        c.last = last;
        if (symbol >= CH_ZERO && symbol <= CH_NINE) begin
            c.op = OP_PUSH;
        end else begin
            unique case (symbol)
                CH_PLUS:  c.op = OP_ADD;
                CH_MINUS: c.op = OP_SUB;
                CH_MUL:   c.op = OP_MUL;
                CH_DIV:   c.op = OP_DIV;
                default:  c.op = OP_NONE;
            endcase
        end
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) q_reg[wp_reg] <= c;
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end else begin
            if (in_valid && in_ready) wp_reg <= !wp_reg;
            if (cmd_valid && cmd_ready) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(in_valid && in_ready) - 2'(cmd_valid && cmd_ready);
        end
    end
endmodule

### rtl/pee_back.sv
module pee_back
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [6:0]  stack_limit,
    input  cmd_t        cmd,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    output logic [31:0] value,
    output logic [1:0]  status,
    output logic        out_valid,
    input  logic        out_ready
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_RDB, S_RDA, S_EXEC, S_DIV, S_TOP, S_OUT} state_t;

    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] rd_reg, a_reg, b_reg, q_reg, r_reg, dm_reg;
    logic [CW-1:0] cnt_reg;
    logic [1:0] err_reg;
    cmd_t cur_reg;
    state_t st_reg;
    logic [5:0] it_reg;
    logic neg_reg;
    logic [AW-1:0] raddr;
    logic [CW-1:0] lim;
    logic [32:0] trial;
    logic [31:0] res;

    assign lim = (int'(stack_limit) > STACK_DEPTH) ? CW'(STACK_DEPTH)
                                                   : CW'(stack_limit);
    assign cmd_ready = (st_reg == S_IDLE);
    assign out_valid = (st_reg == S_OUT);
    assign trial = {r_reg, q_reg[31]} - {1'b0, dm_reg};

    always_comb begin
        unique case (cur_reg.op)
            OP_ADD:  res = a_reg + b_reg;
            OP_SUB:  res = a_reg - b_reg;
            OP_MUL:  res = a_reg * b_reg;
            default: res = 32'(cur_reg.digit);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            cnt_reg <= '0;
            err_reg <= ST_OK;
        end else begin
            unique case (st_reg)
                S_IDLE: if (cmd_valid) begin
                    cur_reg <= cmd;
                    if (err_reg != ST_OK || cmd.op == OP_NONE) begin
                        st_reg <= cmd.last ? S_TOP : S_IDLE;
                    end else if (cmd.op == OP_PUSH) begin
                        a_reg <= '0;
                        st_reg <= S_EXEC;
                    end else if (cnt_reg < CW'(2)) begin
                        err_reg <= ST_UNDER;
                        st_reg <= cmd.last ? S_TOP : S_IDLE;
                    end else begin
                        rd_reg <= mem[AW'(cnt_reg - CW'(1))];
                        cnt_reg <= cnt_reg - CW'(1);
                        st_reg <= S_RDB;
                    end
                end
                S_RDB: begin
                    b_reg <= rd_reg;
                    rd_reg <= mem[AW'(cnt_reg - CW'(1))];
                    cnt_reg <= cnt_reg - CW'(1);
                    st_reg <= S_RDA;
                end
                S_RDA: begin
                    a_reg <= rd_reg;
                    if (cur_reg.op == OP_DIV) begin
                        if (b_reg == '0) begin
                            err_reg <= ST_DIVZERO;
                            st_reg <= cur_reg.last ? S_TOP : S_IDLE;
                        end else begin
                            q_reg <= rd_reg[31] ? -rd_reg : rd_reg;
                            dm_reg <= b_reg[31] ? -b_reg : b_reg;
                            neg_reg <= rd_reg[31] ^ b_reg[31];
                            r_reg <= '0;
                            it_reg <= '0;
                            st_reg <= S_DIV;
                        end
                    end else begin
                        st_reg <= S_EXEC;
                    end
                end
                S_DIV: begin
                    if (!trial[32]) r_reg <= trial[31:0];
                    else r_reg <= {r_reg[30:0], q_reg[31]};
                    q_reg <= {q_reg[30:0], !trial[32]};
                    it_reg <= it_reg + 6'd1;
                    if (it_reg == 6'd31) begin
                        cur_reg.op <= OP_NONE;
                        st_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (cnt_reg >= lim) begin
                        err_reg <= ST_OVER;
                    end else begin
                        mem[AW'(cnt_reg)] <= (cur_reg.op == OP_NONE)
                            ? (neg_reg ? -q_reg : q_reg) : res;
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    st_reg <= cur_reg.last ? S_TOP : S_IDLE;
                end
                S_TOP: begin
                    if (err_reg == ST_OK && cnt_reg == '0) err_reg <= ST_UNDER;
                    rd_reg <= mem[AW'(cnt_reg - CW'(1))];
                    st_reg <= S_OUT;
                end
                S_OUT: if (out_ready) begin
                    cnt_reg <= '0;
                    err_reg <= ST_OK;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign value  = (err_reg == ST_OK) ? rd_reg : 32'd0;
    assign status = err_reg;
endmodule

### rtl/postfix_expression_evaluator_unit.sv
// postfix evaluator: one character per item, one result per expression
// digits push; + - * pop two operands and push; / also runs the 32-step divider
// the back end takes a new item only once idle, after its sequencer and divider finish;
// a last item also waits for the top-of-stack read and any output stall
// reset: aresetn synchronous active low; stack empty, error clear, stack_limit 15
module postfix_expression_evaluator_unit
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // symbol
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // value[31:0], status[33:32], zero fill
);
`include "postfix_expression_evaluator_unit_assert.svh"
    logic [6:0] limit_reg;
    cmd_t cmd;
    logic cmd_valid, cmd_ready;
    logic [31:0] value;
    logic [1:0] status;

    always_ff @(posedge aclk) begin
        if (!aresetn) limit_reg <= 7'd15;
        else if (cfg_wr_en) limit_reg <= cfg_wr_data;
    end

    pee_front u_front (
        .aclk, .aresetn, .symbol(s_tdata), .last(s_tlast), .in_valid(s_tvalid),
        .in_ready(s_tready), .cmd, .cmd_valid, .cmd_ready
    );

    pee_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .aclk, .aresetn, .stack_limit(limit_reg), .cmd, .cmd_valid, .cmd_ready,
        .value, .status, .out_valid(m_tvalid), .out_ready(m_tready)
    );

    assign m_tdata = {6'd0, status, value};

    `PEE_ASSERT_IMPL(a_err_zero, aclk, aresetn, m_tvalid && status != ST_OK, value == 32'd0)
    `PEE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

### test/tb_postfix_expression_evaluator_unit.sv
module tb_postfix_expression_evaluator_unit;
    import pee_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } char_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } eval_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    postfix_expression_evaluator_unit #(.STACK_DEPTH(DEPTH)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor state
    logic [31:0] eval_stack [DEPTH];
    int unsigned stack_fill;
    logic [1:0]  latched_error;
    logic [6:0]  stack_limit;

    char_item_t   pending_chars [$];
    eval_result_t expected_results [$];
    int mismatches;
    int unsigned cycle_count;
    bit   hold_sender;
    int   long_stall;
    bit   s_accepted;
    bit   m_accepted;

    function automatic int unsigned limit_now();
        return (stack_limit > DEPTH) ? DEPTH : stack_limit;
    endfunction

    function automatic void push_operand(logic [31:0] v);
        if (stack_fill >= limit_now()) begin
            latched_error = ST_OVER;
        end else begin
            eval_stack[stack_fill] = v;
            stack_fill++;
        end
    endfunction

    function automatic logic [31:0] divide_trunc(logic [31:0] n, logic [31:0] d);
        logic [31:0] nm;
        logic [31:0] dm;
        logic [31:0] q;
        nm = n[31] ? -n : n;
        dm = d[31] ? -d : d;
        q = nm / dm;
        return (n[31] != d[31]) ? -q : q;
    endfunction

    function automatic void apply_operator(logic [7:0] sym);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        if (stack_fill < 2) begin
            latched_error = ST_UNDER;
            return;
        end
        b = eval_stack[stack_fill - 1];
        a = eval_stack[stack_fill - 2];
        stack_fill -= 2;
        case (sym)
            CH_PLUS:  r = a + b;
            CH_MINUS: r = a - b;
            CH_MUL:   r = a * b;
            default: begin
                if (b == 0) begin
                    latched_error = ST_DIVZERO;
                    return;
                end
                r = divide_trunc(a, b);
            end
        endcase
        push_operand(r);
    endfunction

    function automatic void predict_char(char_item_t it);
        eval_result_t res;
        if (latched_error == ST_OK) begin
            if (it.symbol >= CH_ZERO && it.symbol <= CH_NINE)
                push_operand({24'd0, it.symbol - CH_ZERO});
            else if (it.symbol == CH_PLUS || it.symbol == CH_MINUS ||
                     it.symbol == CH_MUL || it.symbol == CH_DIV)
                apply_operator(it.symbol);
        end
        if (!it.last)
            return;
        res.value = 0;
        if (latched_error == ST_OK) begin
            if (stack_fill == 0)
                latched_error = ST_UNDER;
            else
                res.value = eval_stack[stack_fill - 1];
        end
        if (latched_error != ST_OK)
            res.value = 0;
        res.status = latched_error;
        expected_results.push_back(res);
        stack_fill = 0;
        latched_error = ST_OK;
    endfunction

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** postfix_expression_evaluator_unit: FAILED **");
            $finish;
        end
    end

    // driver
    int send_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            send_gap <= $urandom_range(0, 11);
        end else if (s_tvalid && !s_accepted) begin
            // hold item
        end else if (send_gap > 0 || hold_sender) begin
            s_tvalid <= 0;
            if (send_gap > 0)
                send_gap <= send_gap - 1;
        end else if (pending_chars.size() > 0) begin
            char_item_t it;
            it = pending_chars.pop_front();
            s_tdata <= it.symbol;
            s_tlast <= it.last;
            s_tvalid <= 1;
            send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
        end else begin
            s_tvalid <= 0;
        end
    end

    // prediction at acceptance
    always @(posedge aclk) begin
        s_accepted <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            predict_char('{symbol: s_tdata, last: s_tlast});
    end

    // receiver ready
    int recv_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
            recv_gap <= 0;
        end else if (long_stall > 0) begin
            m_tready <= 0;
            long_stall <= long_stall - 1;
        end else if (recv_gap > 0) begin
            m_tready <= 0;
            recv_gap <= recv_gap - 1;
        end else begin
            m_tready <= 1;
            if (m_accepted)
                recv_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
        end
    end

    // monitor
    always @(posedge aclk) begin
        m_accepted <= aresetn && m_tvalid && m_tready;
        if (aresetn && m_tvalid && m_tready) begin
            eval_result_t exp_r;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end else begin
                exp_r = expected_results.pop_front();
                if (m_tdata[31:0] !== exp_r.value || m_tdata[33:32] !== exp_r.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: value exp %h got %h, status exp %0d got %0d",
                                 exp_r.value, m_tdata[31:0], exp_r.status, m_tdata[33:32]);
                end
            end
        end
    end

    task automatic queue_char(logic [7:0] sym, logic lst);
        pending_chars.push_back('{symbol: sym, last: lst});
    endtask

    task automatic queue_expr(string s);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i], i == s.len() - 1);
    endtask

    task automatic wait_idle();
        while (pending_chars.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(logic [6:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 0;
        stack_limit = v;
    endtask

    function automatic logic [7:0] random_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_op();
        case ($urandom_range(0, 3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_MUL;
            default: return CH_DIV;
        endcase
    endfunction

    // mostly well-formed expressions with random content, some noise
    task automatic queue_random_expr(int unsigned max_ops);
        int depth_now;
        int n_ops;
        int steps;
        depth_now = 0;
        n_ops = $urandom_range(0, max_ops);
        steps = 0;
        while (n_ops > 0 || depth_now != 1) begin
            logic [7:0] sym;
            int r;
            r = $urandom_range(0, 99);
            if (r < 4)
                sym = 8'($urandom);
            else if (r < 7)
                sym = random_op();
            else if (depth_now >= 2 && (n_ops > 0 || depth_now > 1) && r < 55) begin
                sym = random_op();
                depth_now--;
                if (n_ops > 0) n_ops--;
            end else begin
                sym = random_digit();
                depth_now++;
            end
            steps++;
            if (steps > 40) break;
            queue_char(sym, 0);
        end
        queue_char(($urandom_range(0, 4) == 0) ? 8'($urandom) :
                   (($urandom_range(0, 1) == 0) ? CH_PLUS : random_digit()), 1);
    endtask

    initial begin
        aresetn = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        m_tready = 0;
        cycle_count = 0;
        mismatches = 0;
        hold_sender = 0;
        long_stall = 0;
        stack_fill = 0;
        latched_error = ST_OK;
        stack_limit = 7'd15;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed
        queue_expr("34+2*");
        queue_expr("95-");
        queue_expr("9/");
        queue_expr("90/");
        queue_expr("");
        queue_char(8'h00, 1);
        queue_char(8'hff, 1);
        queue_expr("72/1+");
        queue_expr("+5");
        queue_expr("99*9*9*9*9*9*9*9*9*9*9*");
        queue_expr("0 9 -9/");
        queue_expr("12a3");
        wait_idle();

        // limits 1, 0; then 0x80000000 (most negative, 0-2^31) over -1
        write_limit(7'd1);
        queue_expr("12");
        queue_expr("5");
        wait_idle();
        write_limit(7'd0);
        queue_expr("1");
        queue_expr("+");
        wait_idle();
        write_limit(7'd127);
        begin
            string s;
            s = "02";
            for (int i = 0; i < 29; i++) s = {s, "2*"};
            s = {s, "2*-01-/"};
            queue_expr(s);
            s = "";
            for (int i = 0; i < 66; i++) s = {s, "1"};
            queue_expr(s);
        end
        wait_idle();
        write_limit(7'd64);

        // random phases across limits
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1: write_limit(7'd2);
                2: write_limit(7'd15);
                3: write_limit(7'd127);
                4: write_limit(7'd4);
                5: write_limit(7'd64);
                default: ;
            endcase
            for (int e = 0; e < 16; e++)
                queue_random_expr((phase == 3) ? 20 : 6);
            if (phase == 2) begin
                long_stall = 400;
                for (int e = 0; e < 10; e++)
                    queue_random_expr(3);
            end
            if (phase == 4) begin
                hold_sender = 1;
                while (expected_results.size() > 0 || s_tvalid) @(posedge aclk);
                hold_sender = 0;
            end
            wait_idle();
        end

        wait_idle();
        if (mismatches == 0)
            $display("** postfix_expression_evaluator_unit: PASSED **");
        else
            $display("** postfix_expression_evaluator_unit: FAILED **");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/pee_pkg.sv
rtl/pee_front.sv
rtl/pee_back.sv
rtl/postfix_expression_evaluator_unit.sv
test/tb_postfix_expression_evaluator_unit.sv
